>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");

`endif

>>> sv/lpd_pkg.sv
// Package with constants and types of the lidar packet deframer.
package lpd_pkg;

	localparam int unsigned FRAME_LEN = 22;

	localparam logic [7:0] START_BYTE = 8'hFA;
	localparam logic [7:0] ANGLE_BASE = 8'hA0;
	localparam logic [14:0] CHK_MASK = 15'h7FFF;

	localparam logic [4:0] POS_CHK = 5'd20;
	localparam logic [4:0] POS_LAST = 5'(FRAME_LEN - 1);

	typedef logic [4:0] pos_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic fold;
	} chk_ctl_t;

endpackage

>>> sv/lpd_checksum.sv
// Running frame checksum: shift-and-add over little-endian words, then fold to 15 bits.
module lpd_checksum (
	input  logic             clk,
	input  logic             arst_n,
	input  lpd_pkg::chk_ctl_t ctl,
	input  logic [15:0]      word,
	output logic [14:0]      chk
);
	import lpd_pkg::*;

	logic [31:0] acc_q;
	logic [31:0] fold_sum;
	logic [14:0] chk_q;

	assign fold_sum = acc_q + (acc_q >> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= {acc_q[30:0], 1'b0} + {16'd0, word};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fold) begin
			chk_q <= fold_sum[14:0] & CHK_MASK;
		end
	end

	assign chk = chk_q;

endmodule

>>> sv/lidar_packet_deframer_core.sv
// Lidar packet deframer: takes one serial byte per cycle on the item channel and hunts
// for the start byte 0xFA, latching time_us there; the following 21 bytes complete a
// 22-byte frame with no resync inside it. The checksum accumulates one 16-bit word on
// every second byte and is folded when byte 20 arrives, so the match is decided as the
// last byte is taken, and a frame whose checksum matches shows its result on the result
// channel in the cycle right after its last byte; bad frames are dropped. Throughput is
// one byte per cycle; item_ready drops only while the frame waits for its last byte and
// the previous result is still held in the output register and not being taken.
module lidar_packet_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] time_us,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  angle_index,
	output logic [15:0] speed_raw,
	output logic [15:0] distance_0,
	output logic [15:0] signal_0,
	output logic [15:0] distance_1,
	output logic [15:0] signal_1,
	output logic [15:0] distance_2,
	output logic [15:0] signal_2,
	output logic [15:0] distance_3,
	output logic [15:0] signal_3,
	output logic [31:0] frame_time_us
);
	import lpd_pkg::*;

	pos_t        count_q;
	logic [7:0]  frame_q [1:19];
	logic [7:0]  low_q;
	logic [31:0] start_time_q;

	logic        accept;
	logic        is_start;
	logic        hunting;
	logic        at_last;
	logic        match;
	logic        done;
	chk_ctl_t    chk_ctl;
	logic [14:0] chk;

	logic        result_valid_q;
	logic [7:0]  angle_q;
	logic [15:0] speed_q;
	logic [15:0] dist0_q, dist1_q, dist2_q, dist3_q;
	logic [15:0] sig0_q, sig1_q, sig2_q, sig3_q;
	logic [31:0] frame_time_q;

	assign hunting  = (count_q == '0);
	assign at_last  = (count_q == POS_LAST);
	assign is_start = (rx_byte == START_BYTE);

	assign item_ready = !result_valid_q || result_ready || !at_last;
	assign accept     = item_valid && item_ready;

	assign chk_ctl.clear = accept && hunting && is_start;
	assign chk_ctl.add   = accept && count_q[0] && !at_last;
	assign chk_ctl.fold  = accept && (count_q == POS_CHK);

	lpd_checksum u_checksum (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (chk_ctl),
		.word  ({rx_byte, low_q}),
		.chk   (chk)
	);

	assign match = ({rx_byte, low_q} == {1'b0, chk});
	assign done  = accept && at_last && match;

	// advance the frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (hunting) begin
				if (is_start) begin
					count_q <= 5'd1;
				end
			end else if (at_last) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
		end else if (accept && hunting && is_start) begin
			start_time_q <= time_us;
		end
	end

	// hold frame bytes and the low byte of the word in progress
	always_ff @(posedge clk) begin
		if (accept && !hunting && (count_q < POS_CHK)) begin
			frame_q[count_q] <= rx_byte;
		end
		if (accept && !count_q[0]) begin
			low_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			angle_q      <= frame_q[1] - ANGLE_BASE;
			speed_q      <= {frame_q[3], frame_q[2]};
			dist0_q      <= {frame_q[5], frame_q[4]};
			sig0_q       <= {frame_q[7], frame_q[6]};
			dist1_q      <= {frame_q[9], frame_q[8]};
			sig1_q       <= {frame_q[11], frame_q[10]};
			dist2_q      <= {frame_q[13], frame_q[12]};
			sig2_q       <= {frame_q[15], frame_q[14]};
			dist3_q      <= {frame_q[17], frame_q[16]};
			sig3_q       <= {frame_q[19], frame_q[18]};
			frame_time_q <= start_time_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign angle_index   = angle_q;
	assign speed_raw     = speed_q;
	assign distance_0    = dist0_q;
	assign signal_0      = sig0_q;
	assign distance_1    = dist1_q;
	assign signal_1      = sig1_q;
	assign distance_2    = dist2_q;
	assign signal_2      = sig2_q;
	assign distance_3    = dist3_q;
	assign signal_3      = sig3_q;
	assign frame_time_us = frame_time_q;

endmodule

>>> sv/lpd_checker.sv
// Port-level checker for the lidar packet deframer, bound to the top level.
`include "assert_macros.svh"

module lpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [7:0]  rx_byte,
	input logic [31:0] time_us,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  angle_index,
	input logic [15:0] speed_raw,
	input logic [15:0] distance_0,
	input logic [15:0] signal_0,
	input logic [15:0] distance_1,
	input logic [15:0] signal_1,
	input logic [15:0] distance_2,
	input logic [15:0] signal_2,
	input logic [15:0] distance_3,
	input logic [15:0] signal_3,
	input logic [31:0] frame_time_us
);

	logic [183:0] result_word;
	logic [39:0]  item_word;

	assign result_word = {angle_index, speed_raw, distance_0, signal_0, distance_1, signal_1,
		distance_2, signal_2, distance_3, signal_3, frame_time_us};
	assign item_word = {rx_byte, time_us};

	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_word))
	`ASSERT_IMPLY(a_result_drop, clk, arst_n, $fell(result_valid), $past(result_ready))
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !item_ready, result_valid && !result_ready)
	`ASSERT_IMPLY(a_result_source, clk, arst_n, $rose(result_valid), $past(item_valid && item_ready))
	`ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && !item_ready, item_valid && $stable(item_word))

endmodule

bind lidar_packet_deframer_core lpd_checker u_lpd_checker (.*);
